// ===== rtl/ulmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// UV lamp mode and timer controller package
// Shared types, register indexes, limits and reset values.
// ----------------------------------------------------------------------------
package ulmtc_pkg;

   // Field widths
   localparam int TPS_W   = 10;
   localparam int PRESS_W = 7;
   localparam int SETUP_W = 11;
   localparam int MIN_W   = 7;
   localparam int SEC_W   = 6;
   localparam int MODE_W  = 2;

   // Configuration port
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_SECOND = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_TICKS      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP_HOLD_TICKS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_TICKS     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MINUTES      = 3'd4;

   // Lamp modes
   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TIMER = 2'd2;

   // Saturation limits and bounds
   localparam logic [SETUP_W-1:0] UP_SAT  = 11'd1200;
   localparam logic [PRESS_W-1:0] BTN_SAT = 7'd120;
   localparam logic [SEC_W-1:0]   SEC_MAX = 6'd59;
   localparam logic [MIN_W-1:0]   MIN_CAP = 7'd99;

   // Reset values
   localparam logic [TPS_W-1:0]   RST_TICKS_PER_SECOND = 10'd200;
   localparam logic [PRESS_W-1:0] RST_PRESS_TICKS      = 7'd20;
   localparam logic [SETUP_W-1:0] RST_SETUP_HOLD_TICKS = 11'd400;
   localparam logic [PRESS_W-1:0] RST_REPEAT_TICKS     = 7'd60;
   localparam logic [MIN_W-1:0]   RST_MAX_MINUTES      = 7'd90;
   localparam logic [MIN_W-1:0]   RST_MINUTES          = 7'd5;
   localparam logic [SEC_W-1:0]   RST_SECONDS          = 6'd0;

   typedef struct packed {
      logic up_pressed;
      logic down_pressed;
      logic left_pressed;
   } req_type;

   typedef struct packed {
      logic              lamp_on;
      logic [MODE_W-1:0] lamp_mode;
      logic              in_setup;
      logic              editing_seconds;
      logic [MIN_W-1:0]  minutes_left;
      logic [SEC_W-1:0]  seconds_left;
      logic [MIN_W-1:0]  preset_minutes;
      logic [SEC_W-1:0]  preset_seconds;
      logic              time_expired;
   } rsp_type;

   typedef struct packed {
      logic [TPS_W-1:0]   ticks_per_second;
      logic [PRESS_W-1:0] press_ticks;
      logic [SETUP_W-1:0] setup_hold_ticks;
      logic [PRESS_W-1:0] repeat_ticks;
      logic [MIN_W-1:0]   max_minutes;
   } cfg_type;

   typedef struct packed {
      logic [SETUP_W-1:0] up_hold;
      logic [PRESS_W-1:0] down_hold;
      logic [PRESS_W-1:0] left_hold;
      logic [TPS_W-1:0]   tick_prescale;
      logic               lamp_state;
      logic [MODE_W-1:0]  mode_state;
      logic               setup_active;
      logic               press_latched;
      logic               expired_flag;
      logic               field_select;
      logic               combo_prev;
      logic [MIN_W-1:0]   count_minutes;
      logic [SEC_W-1:0]   count_seconds;
      logic [MIN_W-1:0]   preset_min_reg;
      logic [SEC_W-1:0]   preset_sec_reg;
   } state_type;

endpackage

// ===== rtl/ulmtc_step.sv =====
// ----------------------------------------------------------------------------
// UV lamp controller tick step
// Next-state logic for one 5 ms tick: hold counters, prescaler, countdown,
// setup menu and lamp mode handling.
// ----------------------------------------------------------------------------
module ulmtc_step import ulmtc_pkg::*; (
   input  state_type cur_state,
   input  cfg_type   cfg,
   input  req_type   req,
   output state_type next_state
);

   always_comb begin
      state_type          s;
      logic               combo;
      logic               combo_edge;
      logic               left_press;
      logic [MIN_W-1:0]   top;
      logic [SETUP_W-1:0] repeat_ext;

      s          = cur_state;
      combo      = req.up_pressed && req.down_pressed;
      combo_edge = combo && !cur_state.combo_prev;
      top        = (cfg.max_minutes > MIN_CAP) ? MIN_CAP : cfg.max_minutes;
      repeat_ext = {{(SETUP_W-PRESS_W){1'b0}}, cfg.repeat_ticks};

      // Advance the saturating hold counters, clear on release
      if (!req.up_pressed) begin
         s.up_hold = '0;
      end else if (s.up_hold < UP_SAT) begin
         s.up_hold = s.up_hold + 1'b1;
      end
      if (!req.down_pressed) begin
         s.down_hold = '0;
      end else if (s.down_hold < BTN_SAT) begin
         s.down_hold = s.down_hold + 1'b1;
      end
      if (!req.left_pressed) begin
         s.left_hold = '0;
      end else if (s.left_hold < BTN_SAT) begin
         s.left_hold = s.left_hold + 1'b1;
      end

      // Advance the prescaler and, in timer mode with the lamp on, step the countdown on wrap
      s.tick_prescale = s.tick_prescale + 1'b1;
      if (s.tick_prescale >= cfg.ticks_per_second) begin
         s.tick_prescale = '0;
         if (s.lamp_state && s.mode_state == MODE_TIMER) begin
            if (s.count_seconds != '0) begin
               s.count_seconds = s.count_seconds - 1'b1;
            end else if (s.count_minutes != '0) begin
               s.count_minutes = s.count_minutes - 1'b1;
               s.count_seconds = SEC_MAX;
            end else begin
               s.expired_flag  = 1'b1;
               s.count_minutes = s.preset_min_reg;
               s.count_seconds = s.preset_sec_reg;
            end
         end
      end

      s.combo_prev = combo;
      left_press   = s.left_hold >= cfg.press_ticks;

      if (s.setup_active) begin
         // Setup menu: leave on combo, otherwise select field and edit preset
         if (combo) begin
            s.setup_active  = 1'b0;
            s.count_minutes = s.preset_min_reg;
            s.count_seconds = s.preset_sec_reg;
         end else begin
            if (left_press) begin
               if (!s.press_latched) begin
                  s.field_select  = !s.field_select;
                  s.press_latched = 1'b1;
               end
            end else begin
               s.press_latched = 1'b0;
            end
            if (s.field_select) begin
               if (s.up_hold >= repeat_ext && s.preset_sec_reg < SEC_MAX) begin
                  s.preset_sec_reg = s.preset_sec_reg + 1'b1;
                  s.down_hold      = '0;
               end
               if (s.down_hold >= cfg.repeat_ticks && s.preset_sec_reg != '0) begin
                  s.preset_sec_reg = s.preset_sec_reg - 1'b1;
                  s.down_hold      = '0;
               end
            end else begin
               if (s.up_hold >= repeat_ext && s.preset_min_reg < top) begin
                  s.preset_min_reg = s.preset_min_reg + 1'b1;
                  s.down_hold      = '0;
               end
               if (s.down_hold >= cfg.repeat_ticks && s.preset_min_reg > 7'd1) begin
                  s.preset_min_reg = s.preset_min_reg - 1'b1;
                  s.down_hold      = '0;
               end
            end
            if (s.preset_min_reg > top) begin
               s.preset_min_reg = 7'd1;
            end
         end
      end else begin
         // Step the mode on the combo press edge
         if (combo_edge) begin
            s.mode_state = (s.mode_state >= MODE_TIMER) ? MODE_PUSH
                                                        : s.mode_state + 1'b1;
         end
         case (s.mode_state)
            MODE_PUSH: begin
               s.lamp_state = left_press;
            end
            MODE_HOLD: begin
               if (left_press) begin
                  if (!s.press_latched) begin
                     s.lamp_state    = !s.lamp_state;
                     s.press_latched = 1'b1;
                  end
               end else begin
                  s.press_latched = 1'b0;
               end
            end
            default: begin
               if (!s.lamp_state && s.up_hold >= cfg.setup_hold_ticks) begin
                  s.setup_active = 1'b1;
               end
               if (s.expired_flag) begin
                  s.lamp_state = 1'b0;
               end
               if (left_press) begin
                  if (!s.press_latched) begin
                     if (s.expired_flag) begin
                        s.expired_flag = 1'b0;
                        s.lamp_state   = 1'b1;
                     end else begin
                        s.lamp_state = !s.lamp_state;
                     end
                     s.press_latched = 1'b1;
                  end
               end else begin
                  s.press_latched = 1'b0;
               end
            end
         endcase
      end

      next_state = s;
   end

endmodule

// ===== rtl/uv_lamp_mode_timer_controller_top.sv =====
// An accepted transaction goes from the input register to the result register when the latter is free or draining.
// Throughput: one tick transaction per clock cycle unless the result is stalled; the whole
// tick update is one pass of logic between the input register and the result register.
// A stalled result holds both stages; an empty input stage still takes one transaction.
// Reset (synchronous, active high) restores the tick state and the control
// registers to their defaults and empties both pipeline stages.
// ----------------------------------------------------------------------------
// UV lamp mode and timer controller
// Input register, single tick update stage and result register with stall.
// ----------------------------------------------------------------------------
module uv_lamp_mode_timer_controller_top import ulmtc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   state_type state_rst;
   logic      in_valid_ff, in_valid_in;
   req_type   in_req_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;
   logic      adv;

   // Move the input stage forward when the result register is free or draining
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !adv;

   // Tick state after reset
   always_comb begin
      state_rst                = '0;
      state_rst.count_minutes  = RST_MINUTES;
      state_rst.count_seconds  = RST_SECONDS;
      state_rst.preset_min_reg = RST_MINUTES;
      state_rst.preset_sec_reg = RST_SECONDS;
   end

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_data[TPS_W-1:0];
            CSR_PRESS_TICKS:      cfg_in.press_ticks      = csr_data[PRESS_W-1:0];
            CSR_SETUP_HOLD_TICKS: cfg_in.setup_hold_ticks = csr_data[SETUP_W-1:0];
            CSR_REPEAT_TICKS:     cfg_in.repeat_ticks     = csr_data[PRESS_W-1:0];
            CSR_MAX_MINUTES:      cfg_in.max_minutes      = csr_data[MIN_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   ulmtc_step u_step (
      .cur_state  (state_ff),
      .cfg        (cfg_ff),
      .req        (in_req_ff),
      .next_state (state_in)
   );

   // Load the input stage whenever it is empty or moving on
   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second <= RST_TICKS_PER_SECOND;
         cfg_ff.press_ticks      <= RST_PRESS_TICKS;
         cfg_ff.setup_hold_ticks <= RST_SETUP_HOLD_TICKS;
         cfg_ff.repeat_ticks     <= RST_REPEAT_TICKS;
         cfg_ff.max_minutes      <= RST_MAX_MINUTES;
         state_ff                <= state_rst;
         in_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_req_ff <= req_data;
      end
      if (adv && in_valid_ff) begin
         rsp_data_ff.lamp_on         <= state_in.lamp_state;
         rsp_data_ff.lamp_mode       <= state_in.mode_state;
         rsp_data_ff.in_setup        <= state_in.setup_active;
         rsp_data_ff.editing_seconds <= state_in.field_select;
         rsp_data_ff.minutes_left    <= state_in.count_minutes;
         rsp_data_ff.seconds_left    <= state_in.count_seconds;
         rsp_data_ff.preset_minutes  <= state_in.preset_min_reg;
         rsp_data_ff.preset_seconds  <= state_in.preset_sec_reg;
         rsp_data_ff.time_expired    <= state_in.expired_flag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// UV lamp mode and timer controller testbench
// Drives button tick transactions through the controller with random idles
// and stalls, predicts every result from a cycle-free model of the tick
// update, and compares each result field by field. A short table of directed
// ticks comes first, then button gestures steered by the predicted state
// across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ulmtc_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int PLAN_LEN       = 29;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_TICKS    = 200;
   localparam int QUIET_PHASE    = 3;
   localparam int HOLDOFF_PHASE  = 4;
   localparam int HOLDOFF_CYCLES = 64;
   localparam int HOLD_CAP       = 130;
   localparam int DRAIN_CYCLES   = 4;
   localparam int MAX_REPORTS    = 40;
   localparam int IDLE_PERCENT   = 24;

   // Button levels {up, down, left}
   localparam req_type BTN_NONE  = 3'b000;
   localparam req_type BTN_UP    = 3'b100;
   localparam req_type BTN_DOWN  = 3'b010;
   localparam req_type BTN_LEFT  = 3'b001;
   localparam req_type BTN_COMBO = 3'b110;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_e;

   typedef struct packed {
      row_kind_e               kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   value;
      req_type                 buttons;
      logic                    typed;
      rsp_type                 panel;
   } plan_row_t;

   logic                   clock;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_data     = '0;

   int   idle_pct    = IDLE_PERCENT;
   logic holdoff_go  = 1'b0;
   logic holdoff_on  = 1'b0;

   // Predicted controller state and register settings
   state_type st;
   cfg_type   knobs;
   rsp_type   lamp_views_due[$];
   plan_row_t plan [PLAN_LEN];

   int    mismatches        = 0;
   int    results_seen      = 0;
   int    ticks_sent        = 0;
   int    expiry_count      = 0;
   int    setup_entry_count = 0;
   int    knob_sets         = 0;
   longint cycles           = 0;

   uv_lamp_mode_timer_controller_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycles,
                  lamp_views_due.size());
         $display("FAIL uv_lamp_mode_timer_controller_top");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic void reset_controller_model();
      st                     = '0;
      st.count_minutes       = RST_MINUTES;
      st.count_seconds       = RST_SECONDS;
      st.preset_min_reg      = RST_MINUTES;
      st.preset_sec_reg      = RST_SECONDS;
      knobs.ticks_per_second = RST_TICKS_PER_SECOND;
      knobs.press_ticks      = RST_PRESS_TICKS;
      knobs.setup_hold_ticks = RST_SETUP_HOLD_TICKS;
      knobs.repeat_ticks     = RST_REPEAT_TICKS;
      knobs.max_minutes      = RST_MAX_MINUTES;
   endfunction

   // Advance one 5 ms tick and return the panel it leaves behind
   function automatic rsp_type advance_controller(req_type b);
      logic             combo;
      logic             combo_edge;
      logic             left_press;
      logic [MIN_W-1:0] top;
      rsp_type          v;
      combo      = b.up_pressed & b.down_pressed;
      combo_edge = combo & ~st.combo_prev;

      // Saturating hold counters, cleared on release
      if (b.up_pressed) begin
         if (st.up_hold < UP_SAT) st.up_hold = st.up_hold + 1'b1;
      end else begin
         st.up_hold = '0;
      end
      if (b.down_pressed) begin
         if (st.down_hold < BTN_SAT) st.down_hold = st.down_hold + 1'b1;
      end else begin
         st.down_hold = '0;
      end
      if (b.left_pressed) begin
         if (st.left_hold < BTN_SAT) st.left_hold = st.left_hold + 1'b1;
      end else begin
         st.left_hold = '0;
      end

      // Prescaler; count one second down when it wraps in timer mode with lamp on
      st.tick_prescale = st.tick_prescale + 1'b1;
      if (st.tick_prescale >= knobs.ticks_per_second) begin
         st.tick_prescale = '0;
         if (st.lamp_state && st.mode_state == MODE_TIMER) begin
            if (st.count_seconds != 0) begin
               st.count_seconds = st.count_seconds - 1'b1;
            end else if (st.count_minutes != 0) begin
               st.count_minutes = st.count_minutes - 1'b1;
               st.count_seconds = SEC_MAX;
            end else begin
               st.expired_flag  = 1'b1;
               st.count_minutes = st.preset_min_reg;
               st.count_seconds = st.preset_sec_reg;
               expiry_count++;
            end
         end
      end

      st.combo_prev = combo;
      left_press    = st.left_hold >= knobs.press_ticks;

      if (st.setup_active) begin
         // Preset setup menu
         top = (knobs.max_minutes > MIN_CAP) ? MIN_CAP : knobs.max_minutes;
         if (combo) begin
            st.setup_active  = 1'b0;
            st.count_minutes = st.preset_min_reg;
            st.count_seconds = st.preset_sec_reg;
         end else begin
            if (left_press) begin
               if (!st.press_latched) begin
                  st.field_select  = ~st.field_select;
                  st.press_latched = 1'b1;
               end
            end else begin
               st.press_latched = 1'b0;
            end
            if (st.field_select) begin
               if (st.up_hold >= knobs.repeat_ticks && st.preset_sec_reg < SEC_MAX) begin
                  st.preset_sec_reg = st.preset_sec_reg + 1'b1;
                  st.down_hold      = '0;
               end
               if (st.down_hold >= knobs.repeat_ticks && st.preset_sec_reg > 0) begin
                  st.preset_sec_reg = st.preset_sec_reg - 1'b1;
                  st.down_hold      = '0;
               end
            end else begin
               if (st.up_hold >= knobs.repeat_ticks && st.preset_min_reg < top) begin
                  st.preset_min_reg = st.preset_min_reg + 1'b1;
                  st.down_hold      = '0;
               end
               if (st.down_hold >= knobs.repeat_ticks && st.preset_min_reg > 1) begin
                  st.preset_min_reg = st.preset_min_reg - 1'b1;
                  st.down_hold      = '0;
               end
            end
            if (st.preset_min_reg > top) st.preset_min_reg = 7'd1;
         end
      end else begin
         // Step the mode on the press edge of up and down together
         if (combo_edge) begin
            st.mode_state = (st.mode_state == MODE_TIMER) ? MODE_PUSH
                                                          : st.mode_state + 2'd1;
         end
         case (st.mode_state)
            MODE_PUSH: begin
               st.lamp_state = left_press;
            end
            MODE_HOLD: begin
               if (left_press) begin
                  if (!st.press_latched) begin
                     st.lamp_state    = ~st.lamp_state;
                     st.press_latched = 1'b1;
                  end
               end else begin
                  st.press_latched = 1'b0;
               end
            end
            default: begin
               if (!st.lamp_state && st.up_hold >= knobs.setup_hold_ticks) begin
                  st.setup_active = 1'b1;
                  setup_entry_count++;
               end
               if (st.expired_flag) st.lamp_state = 1'b0;
               if (left_press) begin
                  if (!st.press_latched) begin
                     if (st.expired_flag) begin
                        st.expired_flag = 1'b0;
                        st.lamp_state   = 1'b1;
                     end else begin
                        st.lamp_state = ~st.lamp_state;
                     end
                     st.press_latched = 1'b1;
                  end
               end else begin
                  st.press_latched = 1'b0;
               end
            end
         endcase
      end

      v.lamp_on         = st.lamp_state;
      v.lamp_mode       = st.mode_state;
      v.in_setup        = st.setup_active;
      v.editing_seconds = st.field_select;
      v.minutes_left    = st.count_minutes;
      v.seconds_left    = st.count_seconds;
      v.preset_minutes  = st.preset_min_reg;
      v.preset_seconds  = st.preset_sec_reg;
      v.time_expired    = st.expired_flag;
      return v;
   endfunction

   // Panel right after reset, with the lamp as given
   function automatic rsp_type default_panel(logic lamp);
      rsp_type p;
      p                = '0;
      p.lamp_on        = lamp;
      p.lamp_mode      = MODE_PUSH;
      p.minutes_left   = RST_MINUTES;
      p.seconds_left   = RST_SECONDS;
      p.preset_minutes = RST_MINUTES;
      p.preset_seconds = RST_SECONDS;
      return p;
   endfunction

   function automatic plan_row_t tick_row(req_type b);
      plan_row_t row;
      row         = '0;
      row.kind    = ROW_TICK;
      row.buttons = b;
      return row;
   endfunction

   function automatic plan_row_t typed_row(req_type b, rsp_type p);
      plan_row_t row;
      row       = tick_row(b);
      row.typed = 1'b1;
      row.panel = p;
      return row;
   endfunction

   function automatic plan_row_t knob_row(logic [CSR_INDEX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] val);
      plan_row_t row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.value = val;
      return row;
   endfunction

   // Keep a hold length within one to a little over saturation
   function automatic int clip_hold(int n);
      if (n < 1) return 1;
      if (n > HOLD_CAP) return HOLD_CAP;
      return n;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] result %0d: %s", $time, results_seen, what);
   endtask

   task automatic check_panel(rsp_type got, rsp_type want);
      if (got.lamp_on !== want.lamp_on)
         report_mismatch($sformatf("lamp_on got %0d want %0d", got.lamp_on, want.lamp_on));
      if (got.lamp_mode !== want.lamp_mode)
         report_mismatch($sformatf("lamp_mode got %0d want %0d",
                                   got.lamp_mode, want.lamp_mode));
      if (got.in_setup !== want.in_setup)
         report_mismatch($sformatf("in_setup got %0d want %0d", got.in_setup, want.in_setup));
      if (got.editing_seconds !== want.editing_seconds)
         report_mismatch($sformatf("editing_seconds got %0d want %0d",
                                   got.editing_seconds, want.editing_seconds));
      if (got.minutes_left !== want.minutes_left)
         report_mismatch($sformatf("minutes_left got %0d want %0d",
                                   got.minutes_left, want.minutes_left));
      if (got.seconds_left !== want.seconds_left)
         report_mismatch($sformatf("seconds_left got %0d want %0d",
                                   got.seconds_left, want.seconds_left));
      if (got.preset_minutes !== want.preset_minutes)
         report_mismatch($sformatf("preset_minutes got %0d want %0d",
                                   got.preset_minutes, want.preset_minutes));
      if (got.preset_seconds !== want.preset_seconds)
         report_mismatch($sformatf("preset_seconds got %0d want %0d",
                                   got.preset_seconds, want.preset_seconds));
      if (got.time_expired !== want.time_expired)
         report_mismatch($sformatf("time_expired got %0d want %0d",
                                   got.time_expired, want.time_expired));
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (lamp_views_due.size() == 0) begin
            report_mismatch("result arrived with nothing expected");
         end else begin
            check_panel(rsp_data, lamp_views_due.pop_front());
         end
         results_seen++;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (holdoff_on) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   initial begin : receiver_holdoff
      int n;
      wait (holdoff_go);
      @(posedge clock);
      holdoff_on <= 1'b1;
      for (n = 0; n < HOLDOFF_CYCLES; n++) @(posedge clock);
      holdoff_on <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   // Offer one tick, hold it until accepted, then queue its expected panel
   task automatic send_tick(req_type b, logic typed, rsp_type typed_panel);
      rsp_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_controller(b);
      lamp_views_due.push_back(typed ? typed_panel : predicted);
      ticks_sent++;
   endtask

   task automatic press_for(req_type b, int n);
      repeat (n) send_tick(b, 1'b0, '0);
   endtask

   // Drop valid and wait until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      while (lamp_views_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_knob(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val;
      @(posedge clock);
      case (idx)
         CSR_TICKS_PER_SECOND: knobs.ticks_per_second = val[TPS_W-1:0];
         CSR_PRESS_TICKS:      knobs.press_ticks      = val[PRESS_W-1:0];
         CSR_SETUP_HOLD_TICKS: knobs.setup_hold_ticks = val[SETUP_W-1:0];
         CSR_REPEAT_TICKS:     knobs.repeat_ticks     = val[PRESS_W-1:0];
         CSR_MAX_MINUTES:      knobs.max_minutes      = val[MIN_W-1:0];
         default: ;
      endcase
   endtask

   // Register set for one random phase: fast, all zero, all ones, then random small timings with any minutes limit
   task automatic apply_phase_knobs(int phase);
      int tps, press, setup_hold, rpt, max_min;
      case (phase)
         0: begin
            tps = 1; press = 1; setup_hold = 3; rpt = 2; max_min = 2;
         end
         1: begin
            tps = 0; press = 0; setup_hold = 0; rpt = 0; max_min = 0;
         end
         2: begin
            tps = 1023; press = 127; setup_hold = 2047; rpt = 127; max_min = 127;
         end
         default: begin
            tps        = $urandom_range(3);
            press      = $urandom_range(4);
            setup_hold = $urandom_range(24);
            rpt        = $urandom_range(4);
            max_min    = $urandom_range(127);
         end
      endcase
      write_knob(CSR_TICKS_PER_SECOND, CSR_DATA_W'(tps));
      write_knob(CSR_PRESS_TICKS, CSR_DATA_W'(press));
      write_knob(CSR_SETUP_HOLD_TICKS, CSR_DATA_W'(setup_hold));
      write_knob(CSR_REPEAT_TICKS, CSR_DATA_W'(rpt));
      write_knob(CSR_MAX_MINUTES, CSR_DATA_W'(max_min));
      knob_sets++;
   endtask

   // Pick one button gesture from the predicted state, then release
   task automatic play_gesture();
      int         pick;
      int         n;
      logic [2:0] raw;
      pick = $urandom_range(99);
      if (pick < 12) begin
         // Noise: random levels, sometimes one long hold of a single button
         if ($urandom_range(3) == 0) begin
            raw = 3'b001 << $urandom_range(2);
            press_for(raw, $urandom_range(100, HOLD_CAP));
         end else begin
            repeat ($urandom_range(1, 6)) begin
               raw = 3'($urandom_range(7));
               send_tick(raw, 1'b0, '0);
            end
         end
      end else if (st.setup_active) begin
         if (pick < 30) begin
            press_for(BTN_COMBO, $urandom_range(1, 3));
         end else if (pick < 50) begin
            press_for(BTN_LEFT, clip_hold(knobs.press_ticks + $urandom_range(3)));
         end else begin
            n = clip_hold(knobs.repeat_ticks * $urandom_range(1, 3) + $urandom_range(2));
            press_for((pick < 75) ? BTN_UP : BTN_DOWN, n);
         end
      end else if (st.mode_state != MODE_TIMER) begin
         if (pick < 45) begin
            press_for(BTN_COMBO, $urandom_range(1, 3));
         end else if (pick < 85) begin
            press_for(BTN_LEFT, clip_hold(knobs.press_ticks + $urandom_range(3)));
         end else begin
            press_for(BTN_NONE, $urandom_range(1, 10));
         end
      end else if (st.lamp_state) begin
         // Let the countdown run, or switch the lamp off
         if (pick < 75) begin
            press_for(BTN_NONE, $urandom_range(10, 80));
         end else begin
            press_for(BTN_LEFT, clip_hold(knobs.press_ticks + $urandom_range(3)));
         end
      end else begin
         if (pick < 40) begin
            press_for(BTN_UP, clip_hold(knobs.setup_hold_ticks + $urandom_range(2)));
         end else if (pick < 80) begin
            press_for(BTN_LEFT, clip_hold(knobs.press_ticks + $urandom_range(3)));
         end else if (pick < 90) begin
            press_for(BTN_COMBO, $urandom_range(1, 3));
         end else begin
            press_for(BTN_NONE, $urandom_range(1, 5));
         end
      end
      press_for(BTN_NONE, $urandom_range(1, 3));
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      int r;
      int phase;
      int first;
      reset_controller_model();

      // Reset view, a push and a hold toggle, timer entry, setup edits at
      // the minutes bound and floor, field select, exit while the pair
      // stays held, then a lamp-on countdown start
      plan = '{
         typed_row(BTN_NONE, default_panel(1'b0)),
         typed_row(BTN_LEFT, default_panel(1'b0)),
         knob_row(CSR_TICKS_PER_SECOND, 11'd1),
         knob_row(CSR_PRESS_TICKS, 11'd1),
         knob_row(CSR_SETUP_HOLD_TICKS, 11'd2),
         knob_row(CSR_REPEAT_TICKS, 11'd1),
         knob_row(CSR_MAX_MINUTES, 11'd4),
         typed_row(BTN_LEFT, default_panel(1'b1)),
         tick_row(BTN_NONE),
         tick_row(BTN_COMBO),
         tick_row(BTN_COMBO),
         tick_row(BTN_LEFT),
         tick_row(BTN_LEFT),
         tick_row(BTN_NONE),
         tick_row(BTN_COMBO),
         tick_row(BTN_LEFT),
         tick_row(BTN_UP),
         tick_row(BTN_UP),
         tick_row(BTN_UP),
         tick_row(BTN_UP),
         tick_row(BTN_DOWN),
         tick_row(BTN_DOWN),
         tick_row(BTN_LEFT),
         tick_row(BTN_UP),
         tick_row(BTN_DOWN),
         tick_row(BTN_COMBO),
         tick_row(BTN_COMBO),
         tick_row(BTN_COMBO),
         tick_row(BTN_LEFT)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (r = 0; r < PLAN_LEN; r++) begin
         if (plan[r].kind == ROW_CSR) begin
            settle();
            write_knob(plan[r].index, plan[r].value);
         end else begin
            csr_write_en <= 1'b0;
            send_tick(plan[r].buttons, plan[r].typed, plan[r].panel);
         end
      end
      knob_sets++;

      // Random gestures, one register setting per phase
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         apply_phase_knobs(phase);
         csr_write_en <= 1'b0;
         idle_pct     <= (phase == QUIET_PHASE) ? 0 : IDLE_PERCENT;
         if (phase == HOLDOFF_PHASE) holdoff_go = 1'b1;
         first = ticks_sent;
         while (ticks_sent - first < PHASE_TICKS) play_gesture();
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d button ticks over %0d register settings",
               results_seen, ticks_sent, knob_sets);
      $display("Countdown expired %0d times, setup opened %0d times, %0d mismatches",
               expiry_count, setup_entry_count, mismatches);
      if (mismatches == 0) begin
         $display("PASS uv_lamp_mode_timer_controller_top");
      end else begin
         $display("FAIL uv_lamp_mode_timer_controller_top");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ulmtc_pkg.sv
rtl/ulmtc_step.sv
rtl/uv_lamp_mode_timer_controller_top.sv
tb/sv/tb_top.sv
